// ===== design/ncwu_pkg.sv =====
// ----------------------------------------------------------------------------
// ncwu_pkg: shared types and constants of the net criticality weight update
// Holds the payload structs, register indexes and the front-to-back job type.
// ----------------------------------------------------------------------------
`default_nettype none
package ncwu_pkg;

  localparam int unsigned SlackWidthDef = 32;
  localparam int unsigned CritW         = 17;
  localparam int unsigned WeightW       = 32;
  localparam int unsigned DegW          = 16;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [CritW-1:0] OneQ16 = 17'h10000;

  localparam logic [CfgIdxW-1:0] RegWorstSlack = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMomentum   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxWeight  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDegreeLim  = 2'd3;

  typedef struct packed {
    logic signed [SlackWidthDef-1:0] slack_rise;
    logic signed [SlackWidthDef-1:0] slack_fall;
    logic                            pin_in_range;
    logic                            last_pin;
    logic [CritW-1:0]                old_criticality;
    logic [WeightW-1:0]              cur_weight;
    logic [DegW-1:0]                 net_degree;
  } ncwu_in_t;

  typedef struct packed {
    logic [CritW-1:0]                new_criticality;
    logic [WeightW-1:0]              upd_weight;
    logic signed [SlackWidthDef-1:0] worst_pin_slack;
  } ncwu_out_t;

  // One finished net handed from front to back
  typedef struct packed {
    logic signed [SlackWidthDef-1:0] worst_pin_slack;
    logic [CritW-1:0]                crit;
    logic [WeightW-1:0]              weight;
    logic                            high_degree;
  } ncwu_job_t;

endpackage
`default_nettype wire

// ===== design/ncwu_front.sv =====
// ----------------------------------------------------------------------------
// ncwu_front: pin stream front end
// Tracks the running minimum slack and pushes one job per net into a queue.
// ----------------------------------------------------------------------------
`default_nettype none
module ncwu_front
  import ncwu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ncwu_in_t  in_data_i,
  input  wire logic [DegW-1:0] degree_limit_i,
  output logic           job_valid_o,
  input  wire logic      job_pop_i,
  output ncwu_job_t      job_o
);

  localparam int unsigned SlackWidth = SlackWidthDef;
  localparam logic signed [SlackWidth-1:0] MaxPos = {1'b0, {(SlackWidth-1){1'b1}}};

  logic signed [SlackWidth-1:0] min_q, min_d;
  ncwu_job_t                    mem_q [QueueDepth];
  logic                         wptr_q, rptr_q;
  logic [1:0]                   cnt_q;
  logic                         acc, push;
  logic signed [SlackWidth-1:0] pin_min, cur_min;

  assign in_stall = (cnt_q == 2'(QueueDepth));
  assign acc      = in_valid && !in_stall;
  assign push     = acc && in_data_i.last_pin;

  // Pick the worse of rise and fall, fold into the running minimum
  always_comb begin
    pin_min = (in_data_i.slack_rise < in_data_i.slack_fall) ?
              in_data_i.slack_rise : in_data_i.slack_fall;
    cur_min = min_q;
    if (in_data_i.pin_in_range && (pin_min < min_q)) cur_min = pin_min;
    min_d = min_q;
    if (acc) min_d = in_data_i.last_pin ? MaxPos : cur_min;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= MaxPos;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      min_q <= min_d;
      if (push) wptr_q <= ~wptr_q;
      if (job_pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(job_pop_i);
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q].worst_pin_slack <= cur_min;
      mem_q[wptr_q].crit            <= in_data_i.old_criticality;
      mem_q[wptr_q].weight          <= in_data_i.cur_weight;
      mem_q[wptr_q].high_degree     <= in_data_i.net_degree > degree_limit_i;
    end
  end

  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rptr_q];

endmodule
`default_nettype wire

// ===== design/ncwu_back.sv =====
// ----------------------------------------------------------------------------
// ncwu_back: per-net arithmetic sequencer
// Divides, takes two log2, blends, exp2 and scales the weight, step by step.
// ----------------------------------------------------------------------------
`default_nettype none
module ncwu_back
  import ncwu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      job_valid_i,
  output logic           job_pop_o,
  input  wire ncwu_job_t job_i,
  input  wire logic signed [SlackWidthDef-1:0] worst_slack_i,
  input  wire logic [CritW-1:0]   momentum_i,
  input  wire logic [WeightW-1:0] max_weight_i,
  output logic           out_valid,
  input  wire logic      out_stall,
  output ncwu_out_t      out_data_o
);

  localparam int unsigned SlackWidth = SlackWidthDef;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDiv  = 4'd1;
  localparam logic [3:0] StLogA = 4'd2;
  localparam logic [3:0] StLogB = 4'd3;
  localparam logic [3:0] StMix  = 4'd4;
  localparam logic [3:0] StSqrt = 4'd5;
  localparam logic [3:0] StMul  = 4'd6;
  localparam logic [3:0] StFin  = 4'd7;
  localparam logic [3:0] StWgt  = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;

  localparam int unsigned DivW = SlackWidth + 17;

  logic [3:0]          st_q;
  logic [5:0]          cnt_q;
  ncwu_job_t           job_q;
  logic [SlackWidth-1:0] aw_q;
  logic [DivW-1:0]     rem_q;
  logic [16:0]         quo_q;
  logic [16:0]         nc_q;
  logic [17:0]         y_q;
  logic [15:0]         lbits_q, la_q;
  logic [16:0]         l_q;
  logic [31:0]         s_q, r_q;
  logic [63:0]         rad_q, sres_q, sbit_q;
  logic [16:0]         newc_q;
  ncwu_out_t           out_q;
  logic                ov_q;

  logic [35:0]         ysq;
  logic [63:0]         rbit_sum;
  logic [63:0]         rmul;
  logic [49:0]         wmul;
  logic [33:0]         mix;
  logic [16:0]         m_sat, ca;
  logic [15:0]         l_frac;
  logic [SlackWidth:0] as_ext;
  logic [DivW-1:0]     rem_sh;
  logic [DivW-1:0]     aw_ext;

  assign m_sat  = (momentum_i > OneQ16) ? OneQ16 : momentum_i;
  assign ca     = (job_q.crit > OneQ16) ? OneQ16 : job_q.crit;
  assign ysq    = y_q * y_q;
  assign rbit_sum = sres_q + sbit_q;
  assign rmul   = r_q * s_q;
  assign as_ext = -{job_q.worst_pin_slack[SlackWidth-1], job_q.worst_pin_slack};
  assign rem_sh = {rem_q[DivW-2:0], 1'b0};
  assign aw_ext = DivW'(aw_q);
  assign mix    = 34'(m_sat) * 34'(la_q) + 34'(OneQ16 - m_sat) * 34'(lbits_q);
  assign wmul   = 50'(job_q.weight) * (50'(OneQ16) + 50'(newc_q));
  assign l_frac = l_q[15:0];

  assign job_pop_o  = (st_q == StIdle) && job_valid_i;
  assign out_valid  = ov_q;
  assign out_data_o = out_q;

  // Sequence one net through the arithmetic
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (ov_q && !out_stall) ov_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (job_valid_i) begin
            job_q <= job_i;
            aw_q  <= SlackWidth'(-worst_slack_i);
            st_q  <= worst_slack_i[SlackWidth-1] ? StDiv : StWgt;
            newc_q <= job_i.crit;
            nc_q  <= '0;
            quo_q <= '0;
            rem_q <= '0;
            cnt_q <= (worst_slack_i[SlackWidth-1] && job_i.worst_pin_slack[SlackWidth-1]) ?
                     6'd0 : 6'd17;
          end
        end
        StDiv: begin
          // Restoring divide, one quotient bit a cycle
          if (cnt_q == 6'd17) begin
            st_q  <= StLogA;
            cnt_q <= 6'd16;
            y_q   <= 18'(OneQ16) + 18'(ca);
          end else if (cnt_q == 6'd0) begin
            if (as_ext >= {1'b0, aw_q}) begin
              nc_q  <= OneQ16;
              cnt_q <= 6'd17;
            end else begin
              rem_q <= DivW'(as_ext);
              cnt_q <= 6'd1;
            end
          end else begin
            if (rem_sh >= aw_ext) begin
              rem_q <= rem_sh - aw_ext;
              quo_q <= {quo_q[15:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[15:0], 1'b0};
            end
            if (cnt_q == 6'd16) begin
              cnt_q <= 6'd17;
              nc_q  <= (rem_sh >= aw_ext) ? {quo_q[15:0], 1'b1} : {quo_q[15:0], 1'b0};
            end else begin
              cnt_q <= cnt_q + 6'd1;
            end
          end
        end
        StLogA, StLogB: begin
          // One squaring round per cycle
          if (cnt_q == 6'd16 && ((st_q == StLogA) ? ca == OneQ16 : nc_q == OneQ16)) begin
            lbits_q <= '0;
            cnt_q   <= 6'd0;
          end else if (cnt_q == 6'd0) begin
            if (st_q == StLogA) begin
              la_q  <= (ca == OneQ16) ? 16'hFFFF : lbits_q;
              st_q  <= StLogB;
              cnt_q <= 6'd16;
              y_q   <= 18'(OneQ16) + 18'(nc_q);
            end else begin
              st_q <= StMix;
              if (nc_q == OneQ16) lbits_q <= 16'hFFFF;
            end
          end else begin
            if (ysq[35:16] >= 20'h20000) begin
              y_q <= ysq[34:17];
              lbits_q <= {lbits_q[14:0], 1'b1};
            end else begin
              y_q <= ysq[33:16];
              lbits_q <= {lbits_q[14:0], 1'b0};
            end
            cnt_q <= cnt_q - 6'd1;
          end
        end
        StMix: begin
          // Saturated logs stand for exactly one: add the missing unit
          l_q   <= mix[32:16] + 17'(((la_q == 16'hFFFF && ca == OneQ16) ?
                    34'(m_sat) : 34'd0) + ((lbits_q == 16'hFFFF && nc_q == OneQ16) ?
                    34'(OneQ16 - m_sat) : 34'd0) + 34'(mix[15:0]) >> 16);
          r_q   <= 32'h4000_0000;
          s_q   <= 32'h8000_0000;
          cnt_q <= 6'd16;
          st_q  <= StSqrt;
          rad_q <= 64'h2000_0000_0000_0000;
          sres_q <= '0;
          sbit_q <= 64'h4000_0000_0000_0000;
        end
        StSqrt: begin
          // Bit-serial square root of s * 2^30
          if (sbit_q == '0) begin
            s_q  <= sres_q[31:0];
            st_q <= StMul;
          end else begin
            if (rad_q >= rbit_sum) begin
              rad_q  <= rad_q - rbit_sum;
              sres_q <= (sres_q >> 1) + sbit_q;
            end else begin
              sres_q <= sres_q >> 1;
            end
            sbit_q <= sbit_q >> 2;
          end
        end
        StMul: begin
          // Fold in the root for this exponent bit, MSB first
          if (l_frac[cnt_q[3:0] - 4'd1]) r_q <= rmul[61:30];
          if (cnt_q == 6'd1) begin
            st_q <= StFin;
          end else begin
            cnt_q  <= cnt_q - 6'd1;
            st_q   <= StSqrt;
            rad_q  <= {2'b00, s_q, 30'd0};
            sres_q <= '0;
            sbit_q <= 64'h4000_0000_0000_0000;
          end
        end
        StFin: begin
          if (l_q[16]) newc_q <= OneQ16;
          else if (r_q[31:14] >= 18'(OneQ16)) newc_q <= 17'(r_q[31:14] - 18'(OneQ16));
          else newc_q <= '0;
          st_q <= StWgt;
        end
        StWgt: begin
          // Wait for the output register to be free
          if (!ov_q || !out_stall) begin
            out_q.new_criticality <= newc_q;
            out_q.worst_pin_slack <= job_q.worst_pin_slack;
            if (job_q.high_degree) out_q.upd_weight <= job_q.weight;
            else if (wmul[49:16] > {2'b00, max_weight_i}) out_q.upd_weight <= max_weight_i;
            else out_q.upd_weight <= wmul[47:16];
            st_q <= StOut;
          end
        end
        StOut: begin
          ov_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/net_criticality_weight_update_core.sv =====
// Path: without a violation a net goes from the queue straight to StWgt and StOut; with one
// it first runs the divide, two 16-round log2 and 16 bit-serial roots, each root followed
// by a multiply; output stalls can hold a net in StWgt in both cases.
// Throughput: one pin per cycle while the two-entry job queue has room; the back end
// takes a new net only when it is back in StIdle, after the last one has reached StOut.
// Reset: asynchronous active low; registers return to their reset values.
// ----------------------------------------------------------------------------
// net_criticality_weight_update_core: top level
// Configuration registers, pin front end, two-entry job queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none
module net_criticality_weight_update_core
  import ncwu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ncwu_in_t  in_data_i,
  output logic           out_valid,
  input  wire logic      out_stall,
  output ncwu_out_t      out_data_o,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SlackWidth = SlackWidthDef;

  logic signed [SlackWidth-1:0] worst_slack_q;
  logic [CritW-1:0]   momentum_q;
  logic [WeightW-1:0] max_weight_q;
  logic [DegW-1:0]    degree_limit_q;
  logic               job_valid, job_pop;
  ncwu_job_t          job;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worst_slack_q  <= '0;
      momentum_q     <= 17'd32768;
      max_weight_q   <= '1;
      degree_limit_q <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        RegWorstSlack: worst_slack_q  <= SlackWidth'(cfg_data_i);
        RegMomentum:   momentum_q     <= cfg_data_i[CritW-1:0];
        RegMaxWeight:  max_weight_q   <= cfg_data_i[WeightW-1:0];
        RegDegreeLim:  degree_limit_q <= cfg_data_i[DegW-1:0];
        default: ;
      endcase
    end
  end

  ncwu_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .degree_limit_i(degree_limit_q),
    .job_valid_o(job_valid), .job_pop_i(job_pop), .job_o(job)
  );

  ncwu_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_pop_o(job_pop), .job_i(job),
    .worst_slack_i(worst_slack_q), .momentum_i(momentum_q),
    .max_weight_i(max_weight_q), .out_valid, .out_stall, .out_data_o
  );

endmodule
`default_nettype wire

// ===== design/ncwu_checker.sv =====
// ----------------------------------------------------------------------------
// ncwu_checker: port-level checks of the core
// Watches the output and configuration channels over time.
// ----------------------------------------------------------------------------
`default_nettype none
module ncwu_checker
  import ncwu_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire ncwu_out_t out_data_o,
  input wire logic      cfg_ready
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data_o))
    else $error("stalled result changed");

  // A presented result is fully defined
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !$isunknown(out_data_o))
    else $error("result has unknown bits");

  // Configuration is always taken
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready)
    else $error("config not ready");

endmodule

bind net_criticality_weight_update_core ncwu_checker u_chk (
  .clk_i, .rst_ni, .out_valid, .out_stall, .out_data_o, .cfg_ready
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for net_criticality_weight_update_core
// Streams pins of random nets through the core, predicts each net result in
// fixed point and compares it field by field with the core's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import ncwu_pkg::*;

  localparam int unsigned SW = SlackWidthDef;
  localparam logic signed [SW-1:0] SlackMaxPos = {1'b0, {(SW-1){1'b1}}};
  localparam longint unsigned OneQ = 65536;
  localparam int NetLatency = 800;
  localparam longint CycleLimit = 10000000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  ncwu_in_t in_data;
  ncwu_out_t out_data;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  net_criticality_weight_update_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_i(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_o(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Predictor state and configuration copy
  logic signed [SW-1:0] wns_q;
  logic [16:0] mom_q;
  logic [31:0] wmax_q;
  logic [15:0] deg_lim_q;
  logic signed [SW-1:0] min_slack_q;

  ncwu_in_t pin_queue[$];
  ncwu_out_t net_results[$];
  int errors;
  bit idle_free;
  bit in_acc;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned log2_frac(longint unsigned v);
    longint unsigned y, r;
    r = 0;
    if (v >= OneQ) return OneQ;
    y = OneQ + v;
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 16;
      if (y >= 2 * OneQ) begin
        y = y >> 1;
        r |= 64'd1 << i;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned exp2_frac(longint unsigned l);
    longint unsigned r, s;
    r = 64'd1 << 30;
    s = 64'd2 << 30;
    if (l >= OneQ) return 2 * OneQ;
    for (int i = 15; i >= 0; i--) begin
      s = int_sqrt(s << 30);
      if ((l >> i) & 1) r = (r * s) >> 30;
    end
    return r >> 14;
  endfunction

  // Advance the running minimum; produce a net result at the last pin
  task automatic predict_pin(input ncwu_in_t p);
    ncwu_out_t res;
    logic signed [SW-1:0] pmin, ns;
    longint unsigned aw, as_, nc, m, ca, l, e, newc, neww;
    if (p.pin_in_range) begin
      pmin = (p.slack_rise < p.slack_fall) ? p.slack_rise : p.slack_fall;
      if (pmin < min_slack_q) min_slack_q = pmin;
    end
    if (!p.last_pin) return;
    ns = min_slack_q;
    min_slack_q = SlackMaxPos;
    newc = p.old_criticality;
    if (wns_q < 0) begin
      aw = -longint'(wns_q);
      nc = 0;
      if (ns < 0) begin
        as_ = -longint'(ns);
        nc = (as_ >= aw) ? OneQ : ((as_ << 16) / aw);
        if (nc > OneQ) nc = OneQ;
      end
      m = (mom_q > OneQ) ? OneQ : mom_q;
      ca = (p.old_criticality > OneQ) ? OneQ : p.old_criticality;
      l = (m * log2_frac(ca) + (OneQ - m) * log2_frac(nc)) >> 16;
      e = exp2_frac(l);
      newc = (e >= OneQ) ? e - OneQ : 0;
      if (newc > OneQ) newc = OneQ;
    end
    if (p.net_degree > deg_lim_q) begin
      neww = p.cur_weight;
    end else begin
      neww = (longint'(p.cur_weight) * (OneQ + newc)) >> 16;
      if (neww > wmax_q) neww = wmax_q;
    end
    res.new_criticality = newc[16:0];
    res.upd_weight = neww[31:0];
    res.worst_pin_slack = ns;
    net_results.push_back(res);
  endtask

  function automatic logic [31:0] rand_slack();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(-int'($urandom_range(0, 400000)));
      3: return 32'($urandom_range(0, 400000));
      default: return $urandom;
    endcase
  endfunction

  function automatic ncwu_in_t rand_pin(bit last);
    ncwu_in_t p;
    p.slack_rise = rand_slack();
    p.slack_fall = rand_slack();
    p.pin_in_range = ($urandom_range(0, 4) != 0);
    p.last_pin = last;
    case ($urandom_range(0, 3))
      0: p.old_criticality = 17'(OneQ);
      1: p.old_criticality = 17'($urandom);
      default: p.old_criticality = 17'($urandom_range(0, 65536));
    endcase
    p.cur_weight = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
    p.net_degree = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    return p;
  endfunction

  // Queue one net of a given pin count
  task automatic queue_net(int pins);
    for (int i = 0; i < pins; i++) pin_queue.push_back(rand_pin(i == pins - 1));
  endtask

  // Write one register in idle, updating the predictor copy
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegWorstSlack: wns_q = val;
      RegMomentum:   mom_q = val[16:0];
      RegMaxWeight:  wmax_q = val;
      RegDegreeLim:  deg_lim_q = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every pin is sent and every net result has come back
  task automatic drain();
    wait (pin_queue.size() == 0 && !in_valid);
    wait (net_results.size() == 0);
    repeat (NetLatency) @(posedge clk);
  endtask

  // Driver: present pins with random idle bursts
  int in_gap;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (in_valid && !in_acc) begin
      // hold the stalled transaction
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (pin_queue.size() != 0) begin
      if (!idle_free && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else begin
        in_data <= pin_queue.pop_front();
        in_valid <= 1'b1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Predict on each accepted pin and note the acceptance for the driver
  always @(posedge clk) begin
    in_acc = rst_n && in_valid && !in_stall;
    if (in_acc) predict_pin(in_data);
  end

  // Receiver stall in bursts
  int out_gap;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap--;
    end else if (!idle_free && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      out_gap = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each net result with the oldest prediction
  always @(posedge clk) begin
    ncwu_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (net_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_res = net_results.pop_front();
        if (out_data.new_criticality !== exp_res.new_criticality) begin
          $display("%0t: new_criticality exp %h got %h", $time,
                   exp_res.new_criticality, out_data.new_criticality);
          errors++;
        end
        if (out_data.upd_weight !== exp_res.upd_weight) begin
          $display("%0t: upd_weight exp %h got %h", $time,
                   exp_res.upd_weight, out_data.upd_weight);
          errors++;
        end
        if (out_data.worst_pin_slack !== exp_res.worst_pin_slack) begin
          $display("%0t: worst_pin_slack exp %h got %h", $time,
                   exp_res.worst_pin_slack, out_data.worst_pin_slack);
          errors++;
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    ncwu_in_t p;
    int sent;
    errors = 0;
    cycles = 0;
    idle_free = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = RegWorstSlack;
    cfg_data = '0;
    in_data = '0;
    wns_q = '0;
    mom_q = 17'd32768;
    wmax_q = 32'hFFFF_FFFF;
    deg_lim_q = 16'hFFFF;
    min_slack_q = SlackMaxPos;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: no violation, criticality above one passes through
    p = rand_pin(1'b1);
    p.old_criticality = 17'h1FFFF;
    p.pin_in_range = 1'b1;
    pin_queue.push_back(p);
    // no counting pin: net slack stays at max positive
    p = rand_pin(1'b0); p.pin_in_range = 1'b0; pin_queue.push_back(p);
    p = rand_pin(1'b1); p.pin_in_range = 1'b0; pin_queue.push_back(p);
    drain();

    write_reg(RegWorstSlack, 32'hFFFE_0000);
    write_reg(RegMomentum, 32'd0);
    write_reg(RegMaxWeight, 32'h0002_0000);
    write_reg(RegDegreeLim, 32'd8);
    // extremes: most negative slack, criticality one, high degree, zero weight
    p = rand_pin(1'b0); p.pin_in_range = 1'b1;
    p.slack_rise = 32'h8000_0000; p.slack_fall = 32'h7FFF_FFFF; pin_queue.push_back(p);
    p = rand_pin(1'b1); p.old_criticality = 17'(OneQ); p.net_degree = 16'd9;
    pin_queue.push_back(p);
    p = rand_pin(1'b1); p.pin_in_range = 1'b1; p.slack_rise = -32'sd65536;
    p.old_criticality = 17'h1FFFF; p.cur_weight = 32'hFFFF_FFFF; p.net_degree = 16'd0;
    pin_queue.push_back(p);
    p = rand_pin(1'b1); p.old_criticality = '0; p.cur_weight = '0; p.net_degree = 16'd8;
    pin_queue.push_back(p);
    drain();

    write_reg(RegWorstSlack, 32'h8000_0000);
    write_reg(RegMomentum, 32'h1FFFF);
    write_reg(RegDegreeLim, 32'd0);
    write_reg(RegMaxWeight, 32'd0);
    queue_net(3);
    queue_net(1);
    drain();

    // Random phases across several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(RegWorstSlack, 32'(-int'($urandom_range(1, 300000))));
          write_reg(RegMomentum, 32'($urandom_range(0, 65536)));
          write_reg(RegMaxWeight, 32'hFFFF_FFFF);
          write_reg(RegDegreeLim, 32'hFFFF);
        end
        1: write_reg(RegWorstSlack, 32'hFFFF_FFFF);
        2: write_reg(RegWorstSlack, 32'd0);
        3: begin
          write_reg(RegWorstSlack, $urandom | 32'h8000_0000);
          write_reg(RegMomentum, 32'd65536);
          write_reg(RegMaxWeight, $urandom);
          write_reg(RegDegreeLim, 32'($urandom));
        end
        4: write_reg(RegMomentum, 32'($urandom_range(0, 131071)));
        default: write_reg(RegWorstSlack, 32'(-int'($urandom_range(1, 300000))));
      endcase
      if (ph == 5) idle_free = 1'b1;
      sent = 0;
      while (sent < 330) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        queue_net(n);
        sent += n;
      end
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
